// ===== src/fwst_pkg.sv =====
// Shared types and constants for the firmware transfer session tracker.
// Used by every module under src; depends on nothing.
package fwst_pkg;

    // Default chunk limits, handed to the top-level parameters
    localparam int P_MIN_CHUNK = 20;
    localparam int P_MAX_CHUNK = 512;

    // Link framing overhead subtracted from the MTU, and percent scale
    localparam int MTU_OVERHEAD = 3;
    localparam int PCT_SCALE    = 100;

    // Serial divider sizing
    localparam int DQ_W        = 33;  // dividend/quotient shift register
    localparam int DIV_CNT_W   = 6;   // step counter, holds CHUNK_STEPS
    localparam int PCT_STEPS   = 7;   // percent quotient is below 128
    localparam int CHUNK_STEPS = 33;  // size + chunk - 1 needs 33 bits

    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        CMD_OPEN    = 3'd0,
        CMD_MTU     = 3'd1,
        CMD_CONFIRM = 3'd2,
        CMD_STATUS  = 3'd3,
        CMD_REWIND  = 3'd4,
        CMD_ABORT   = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE         = 3'd0,
        PH_STARTING     = 3'd1,
        PH_TRANSFERRING = 3'd2,
        PH_FLUSHING     = 3'd3,
        PH_FINISHING    = 3'd4,
        PH_COMPLETED    = 3'd5,
        PH_FAILED       = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        SK_READY    = 3'd0,
        SK_PROGRESS = 3'd1,
        SK_ERROR    = 3'd2,
        SK_FINISHED = 3'd3,
        SK_UNKNOWN  = 3'd4
    } t_skind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_TOTAL   = 3'd0,
        CFG_CODE_READY    = 3'd1,
        CFG_CODE_PROGRESS = 3'd2,
        CFG_CODE_ERROR    = 3'd3,
        CFG_CODE_FINISHED = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_PCT_LOAD,
        ST_PCT_RUN,
        ST_CHK_LOAD,
        ST_CHK_RUN,
        ST_DONE
    } t_state;

    // One input transaction
    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] mtu_size;
        logic [15:0] written_length;
        logic [2:0]  status_count;
        logic [7:0]  status_byte0;
        logic [7:0]  status_byte1;
        logic [7:0]  status_byte2;
        logic [7:0]  status_byte3;
        logic [7:0]  status_byte4;
    } t_in_item;

    // One result transaction
    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] bytes_sent;
        logic [31:0] bytes_confirmed;
        logic [6:0]  percent;
        logic [15:0] chunk_size;
        logic [31:0] total_chunks;
        logic [15:0] chunk_length;
        logic        chunk_has_data;
        logic        chunk_is_last;
        logic [2:0]  status_kind;
        logic [7:0]  status_error_code;
        logic [7:0]  raw_status;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic latch_in;
        logic apply;
        logic div_pct;
        logic div_chunk;
        logic cap_pct;
        logic cap_chunk;
        logic load_out;
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_busy;
    } t_dp_status;

endpackage

// ===== src/firmware_transfer_session_tracker.sv =====
// Top level of the firmware transfer session tracker: controller, datapath, config port.
// Depends on fwst_pkg, fwst_ctrl, fwst_dpath (which holds fwst_div).
//
//  channel  handshake                 payload
//  -------  ------------------------  ----------------------------------
//  input    i_in_valid / o_in_stall   i_in_data  (t_in_item)
//  output   o_out_valid / i_out_stall o_out_data (t_out_item)
//  config   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each transaction runs two serial divisions, 7 steps for percent and 33 for the chunk
// count, one bit per cycle through a single shared unit; the input stays stalled until
// the result is loaded.
// Synchronous active-low reset; config and session state reset at once, no sweep.
// A held result waits in the output register; the next transaction is accepted while
// it waits, and processing holds before the result load until the register frees up.
module firmware_transfer_session_tracker import fwst_pkg::*; #(
    parameter int MIN_CHUNK = P_MIN_CHUNK,
    parameter int MAX_CHUNK = P_MAX_CHUNK
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_stat;

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;

    fwst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    fwst_dpath #(
        .MIN_CHUNK (MIN_CHUNK),
        .MAX_CHUNK (MAX_CHUNK)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    // An accepted transaction blocks the input for at least the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // Percent never exceeds full scale
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.percent <= 7'd100))
        else $error("percent above 100");

    // Next chunk never longer than the chunk size
    a_len_le_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.chunk_length <= o_out_data.chunk_size))
        else $error("chunk length above chunk size");

    // No data left means a zero-length chunk
    a_len_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.chunk_has_data) |-> (o_out_data.chunk_length == 16'd0))
        else $error("nonzero chunk length without data");
`endif

endmodule

// ===== src/fwst_div.sv =====
// Restoring serial divider, one quotient bit per cycle, preloadable remainder.
// Depends on fwst_pkg.
module fwst_div import fwst_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [31:0]          i_rem_init,
    input  logic [DQ_W-1:0]      i_dq_init,
    input  logic [DIV_CNT_W-1:0] i_steps,
    input  logic [31:0]          i_divisor,
    output logic                 o_busy,
    output logic [DQ_W-1:0]      o_quotient
);

    logic [31:0]          r_rem;
    logic [DQ_W-1:0]      r_dq;
    logic [31:0]          r_div;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic [32:0] w_trial;
    logic        w_ge;
    logic [32:0] w_diff;

    // One step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_dq[DQ_W-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem_init;
            r_dq  <= i_dq_init;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
            r_dq  <= {r_dq[DQ_W-2:0], w_ge};
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_dq;

endmodule

// ===== src/fwst_dpath.sv =====
// Datapath: config registers, session state, command update, divisions, result register.
// Depends on fwst_pkg and fwst_div.
module fwst_dpath import fwst_pkg::*; #(
    parameter int MIN_CHUNK = P_MIN_CHUNK,
    parameter int MAX_CHUNK = P_MAX_CHUNK
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  t_in_item             i_in_data,
    input  t_ctrl_cmd            i_cmd,
    output t_dp_status           o_stat,
    output t_out_item            o_out_data
);

    // Configuration registers
    logic [31:0] r_image_total;
    logic [7:0]  r_code_ready;
    logic [7:0]  r_code_progress;
    logic [7:0]  r_code_error;
    logic [7:0]  r_code_finished;

    // Session state
    logic [31:0] r_size;
    logic [31:0] r_sent;
    logic [31:0] r_conf;
    logic [15:0] r_chunk;
    t_phase      r_phase;

    // Per-transaction working registers
    t_in_item    r_in;
    t_skind      r_kind;
    logic [7:0]  r_ecode;
    logic [7:0]  r_raw;
    logic [6:0]  r_pct;
    logic [31:0] r_chunks;
    t_out_item   r_out;

    logic [31:0] n_size;
    logic [31:0] n_sent;
    logic [31:0] n_conf;
    logic [15:0] n_chunk;
    t_phase      n_phase;
    t_skind      n_kind;
    logic [7:0]  n_ecode;
    logic [7:0]  n_raw;

    logic signed [17:0] w_usable;
    logic signed [17:0] w_lo;
    logic signed [17:0] w_hi;
    logic [15:0]        w_clamped;
    logic [32:0]        w_sum;
    logic [31:0]        w_sent_sat;
    logic [31:0]        w_prog_cnt;
    logic [31:0]        w_prog_sat;

    logic [38:0]          w_prod;
    logic [32:0]          w_chk_num;
    logic                 w_div_start;
    logic [31:0]          w_rem_init;
    logic [DQ_W-1:0]      w_dq_init;
    logic [DIV_CNT_W-1:0] w_steps;
    logic [31:0]          w_divisor;
    logic                 w_div_busy;
    logic [DQ_W-1:0]      w_quo;

    logic [31:0] w_left;
    logic        w_none;
    logic [15:0] w_len;
    logic        w_last;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_total   <= '0;
            r_code_ready    <= 8'd1;
            r_code_progress <= 8'd2;
            r_code_error    <= 8'd3;
            r_code_finished <= 8'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_TOTAL:   r_image_total   <= i_cfg_data;
                CFG_CODE_READY:    r_code_ready    <= i_cfg_data[7:0];
                CFG_CODE_PROGRESS: r_code_progress <= i_cfg_data[7:0];
                CFG_CODE_ERROR:    r_code_error    <= i_cfg_data[7:0];
                CFG_CODE_FINISHED: r_code_finished <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in <= i_in_data;
        end
    end

    // Chunk size: MTU less overhead, raised to the minimum, then capped
    always_comb begin
        w_usable  = $signed({2'b00, r_in.mtu_size}) - $signed(18'(MTU_OVERHEAD));
        w_lo      = (w_usable < $signed(18'(MIN_CHUNK))) ? $signed(18'(MIN_CHUNK)) : w_usable;
        w_hi      = (w_lo > $signed(18'(MAX_CHUNK))) ? $signed(18'(MAX_CHUNK)) : w_lo;
        w_clamped = w_hi[15:0];
    end

    // Saturating sent offset and progress count
    always_comb begin
        w_sum      = {1'b0, r_sent} + {17'b0, r_in.written_length};
        w_sent_sat = (w_sum > {1'b0, r_size}) ? r_size : w_sum[31:0];
        w_prog_cnt = (r_in.status_count >= 3'd5) ?
                     {r_in.status_byte4, r_in.status_byte3,
                      r_in.status_byte2, r_in.status_byte1} : 32'd0;
        w_prog_sat = (w_prog_cnt > r_size) ? r_size : w_prog_cnt;
    end

    // Command update
    always_comb begin
        n_size  = r_size;
        n_sent  = r_sent;
        n_conf  = r_conf;
        n_chunk = r_chunk;
        n_phase = r_phase;
        n_kind  = SK_UNKNOWN;
        n_ecode = '0;
        n_raw   = '0;
        case (r_in.cmd)
            CMD_OPEN: begin
                n_size  = r_image_total;
                n_sent  = '0;
                n_conf  = '0;
                n_chunk = w_clamped;
                n_phase = PH_STARTING;
            end
            CMD_MTU: begin
                n_chunk = w_clamped;
            end
            CMD_CONFIRM: begin
                n_sent = w_sent_sat;
                if (r_phase == PH_STARTING) n_phase = PH_TRANSFERRING;
                if (w_sent_sat >= r_size && r_size != '0) n_phase = PH_FLUSHING;
            end
            CMD_STATUS: begin
                if (r_in.status_count != 3'd0) begin
                    n_raw = r_in.status_byte0;
                    if (r_in.status_byte0 == r_code_ready) begin
                        n_kind = SK_READY;
                        if (r_phase == PH_STARTING) n_phase = PH_TRANSFERRING;
                    end else if (r_in.status_byte0 == r_code_progress) begin
                        n_kind = SK_PROGRESS;
                        n_conf = w_prog_sat;
                        if (r_phase == PH_STARTING) n_phase = PH_TRANSFERRING;
                    end else if (r_in.status_byte0 == r_code_error) begin
                        n_kind = SK_ERROR;
                        if (r_in.status_count >= 3'd2) n_ecode = r_in.status_byte1;
                        n_phase = PH_FAILED;
                    end else if (r_in.status_byte0 == r_code_finished) begin
                        n_kind  = SK_FINISHED;
                        n_conf  = r_size;
                        n_phase = PH_COMPLETED;
                    end
                end
            end
            CMD_REWIND: begin
                n_sent = '0;
                n_conf = '0;
                if (r_phase != PH_IDLE) n_phase = PH_STARTING;
            end
            CMD_ABORT: begin
                n_size  = '0;
                n_sent  = '0;
                n_conf  = '0;
                n_chunk = 16'(MAX_CHUNK);
                n_phase = PH_IDLE;
            end
            default: ;
        endcase
    end

    // Session state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= '0;
            r_sent  <= '0;
            r_conf  <= '0;
            r_chunk <= 16'(MAX_CHUNK);
            r_phase <= PH_IDLE;
        end else if (i_cmd.apply) begin
            r_size  <= n_size;
            r_sent  <= n_sent;
            r_conf  <= n_conf;
            r_chunk <= n_chunk;
            r_phase <= n_phase;
        end
    end

    // Status decode results for this transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_kind  <= n_kind;
            r_ecode <= n_ecode;
            r_raw   <= n_raw;
        end
    end

    // Divider operands: percent preloads the high bits, its quotient fits 7 bits
    always_comb begin
        w_prod      = 39'(r_conf) * 39'(PCT_SCALE);
        w_chk_num   = {1'b0, r_size} + {17'b0, r_chunk} - 33'd1;
        w_div_start = i_cmd.div_pct | i_cmd.div_chunk;
        if (i_cmd.div_pct) begin
            w_rem_init = w_prod[38:PCT_STEPS];
            w_dq_init  = {w_prod[PCT_STEPS-1:0], {(DQ_W-PCT_STEPS){1'b0}}};
            w_steps    = DIV_CNT_W'(PCT_STEPS);
            w_divisor  = r_size;
        end else begin
            w_rem_init = '0;
            w_dq_init  = w_chk_num;
            w_steps    = DIV_CNT_W'(CHUNK_STEPS);
            w_divisor  = {16'b0, r_chunk};
        end
    end

    fwst_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_rem_init (w_rem_init),
        .i_dq_init  (w_dq_init),
        .i_steps    (w_steps),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    // Quotient capture, zero when the divisor is zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_pct) begin
            r_pct <= (r_size == '0) ? '0 : w_quo[PCT_STEPS-1:0];
        end
        if (i_cmd.cap_chunk) begin
            r_chunks <= (r_chunk == '0) ? '0 : w_quo[31:0];
        end
    end

    // Next chunk description
    always_comb begin
        w_left = r_size - r_sent;
        w_none = (r_sent >= r_size) || (r_chunk == '0);
        w_len  = '0;
        w_last = (r_size != '0);
        if (!w_none) begin
            w_len  = (w_left < {16'b0, r_chunk}) ? w_left[15:0] : r_chunk;
            w_last = (w_left <= {16'b0, r_chunk});
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.phase             <= r_phase;
            r_out.bytes_sent        <= r_sent;
            r_out.bytes_confirmed   <= r_conf;
            r_out.percent           <= r_pct;
            r_out.chunk_size        <= r_chunk;
            r_out.total_chunks      <= r_chunks;
            r_out.chunk_length      <= w_len;
            r_out.chunk_has_data    <= !w_none;
            r_out.chunk_is_last     <= w_last;
            r_out.status_kind       <= r_kind;
            r_out.status_error_code <= r_ecode;
            r_out.raw_status        <= r_raw;
        end
    end

    assign o_stat.div_busy = w_div_busy;
    assign o_out_data      = r_out;

endmodule

// ===== src/fwst_ctrl.sv =====
// Controller: sequences capture, update, the two divisions and the result hand-off.
// Depends on fwst_pkg.
module fwst_ctrl import fwst_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    input  t_dp_status i_stat,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    // Result register can take a new value
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (i_in_valid) n_state = ST_APPLY;
            ST_APPLY:    n_state = ST_PCT_LOAD;
            ST_PCT_LOAD: n_state = ST_PCT_RUN;
            ST_PCT_RUN:  if (!i_stat.div_busy) n_state = ST_CHK_LOAD;
            ST_CHK_LOAD: n_state = ST_CHK_RUN;
            ST_CHK_RUN:  if (!i_stat.div_busy) n_state = ST_DONE;
            ST_DONE:     if (w_out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall     = 1'b0;
                o_cmd.latch_in = i_in_valid;
            end
            ST_APPLY:    o_cmd.apply     = 1'b1;
            ST_PCT_LOAD: o_cmd.div_pct   = 1'b1;
            ST_PCT_RUN:  o_cmd.cap_pct   = !i_stat.div_busy;
            ST_CHK_LOAD: o_cmd.div_chunk = 1'b1;
            ST_CHK_RUN:  o_cmd.cap_chunk = !i_stat.div_busy;
            ST_DONE:     o_cmd.load_out  = w_out_free;
            default: ;
        endcase
    end

    // State and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for firmware_transfer_session_tracker: directed table, then random
// sessions checked by an in-bench session model. Depends on fwst_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
    import fwst_pkg::*;

    localparam int RESET_CYCLES    = 12;
    localparam int STUCK_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 75;

    // Command codes the block leaves unused
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    // Status code values after reset, plus a value no code uses and a value all codes share
    localparam logic [7:0] RST_CODE_READY    = 8'd1;
    localparam logic [7:0] RST_CODE_PROGRESS = 8'd2;
    localparam logic [7:0] RST_CODE_ERROR    = 8'd3;
    localparam logic [7:0] RST_CODE_FINISHED = 8'd4;
    localparam logic [7:0] UNUSED_CODE       = 8'hFF;
    localparam logic [7:0] SHARED_CODE       = 8'h00;

    // One row of the directed plan: a register write or a transaction
    typedef struct packed {
        logic        is_cfg;
        t_cfg_idx    cfg_idx;
        logic [31:0] cfg_val;
        t_in_item    item;
        logic        fixed;
        t_out_item   want;
    } t_step_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    // Session model state and its copy of the registers
    logic [31:0] cfg_image    = '0;
    logic [7:0]  cfg_ready    = RST_CODE_READY;
    logic [7:0]  cfg_progress = RST_CODE_PROGRESS;
    logic [7:0]  cfg_error    = RST_CODE_ERROR;
    logic [7:0]  cfg_finished = RST_CODE_FINISHED;
    logic [31:0] sess_size    = '0;
    logic [31:0] sent_ofs     = '0;
    logic [31:0] conf_cnt     = '0;
    logic [15:0] cur_chunk    = 16'(P_MAX_CHUNK);
    t_phase      cur_phase    = PH_IDLE;

    t_out_item   pending_reports[$];
    t_step_row   plan[$];
    int          fail_count = 0;
    bit          steady = 1'b0;   // no idling on either side while set
    logic        row_fixed;       // typed expectation for the transaction on the bus
    t_out_item   row_want;

    firmware_transfer_session_tracker uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic note_failure(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            note_failure($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // MTU minus framing overhead, clamped to the chunk limits
    function automatic logic [15:0] clamp_chunk(input logic [15:0] mtu);
        int usable;
        usable = int'(mtu) - MTU_OVERHEAD;
        if (usable < P_MIN_CHUNK) usable = P_MIN_CHUNK;
        if (usable > P_MAX_CHUNK) usable = P_MAX_CHUNK;
        return 16'(usable);
    endfunction

    // Applies one command to the session model and builds the report it yields
    task automatic predict_session_report(input t_in_item it, output t_out_item rep);
        logic [32:0] sum;
        logic [63:0] wide;
        logic [31:0] remain;
        logic [31:0] word;
        logic [15:0] next_len;
        int          nbytes;
        t_skind      kind;
        logic [7:0]  ecode;
        logic [7:0]  raw;
        logic        has;
        logic        last;
        kind  = SK_UNKNOWN;
        ecode = '0;
        raw   = '0;
        case (it.cmd)
            CMD_OPEN: begin
                sess_size = cfg_image;
                sent_ofs  = '0;
                conf_cnt  = '0;
                cur_chunk = clamp_chunk(it.mtu_size);
                cur_phase = PH_STARTING;
            end
            CMD_MTU: cur_chunk = clamp_chunk(it.mtu_size);
            CMD_CONFIRM: begin
                sum = {1'b0, sent_ofs} + {17'b0, it.written_length};
                sent_ofs = (sum > sess_size) ? sess_size : sum[31:0];
                if (cur_phase == PH_STARTING) cur_phase = PH_TRANSFERRING;
                if (sent_ofs >= sess_size && sess_size != 0) cur_phase = PH_FLUSHING;
            end
            CMD_STATUS: begin
                nbytes = (it.status_count > 3'd5) ? 5 : int'(it.status_count);
                if (nbytes != 0) begin
                    raw = it.status_byte0;
                    if (raw == cfg_ready) begin
                        kind = SK_READY;
                        if (cur_phase == PH_STARTING) cur_phase = PH_TRANSFERRING;
                    end else if (raw == cfg_progress) begin
                        kind = SK_PROGRESS;
                        word = '0;
                        if (nbytes >= 5)
                            word = {it.status_byte4, it.status_byte3,
                                    it.status_byte2, it.status_byte1};
                        conf_cnt = (word > sess_size) ? sess_size : word;
                        if (cur_phase == PH_STARTING) cur_phase = PH_TRANSFERRING;
                    end else if (raw == cfg_error) begin
                        kind = SK_ERROR;
                        if (nbytes >= 2) ecode = it.status_byte1;
                        cur_phase = PH_FAILED;
                    end else if (raw == cfg_finished) begin
                        kind = SK_FINISHED;
                        conf_cnt = sess_size;
                        cur_phase = PH_COMPLETED;
                    end
                end
            end
            CMD_REWIND: begin
                sent_ofs = '0;
                conf_cnt = '0;
                if (cur_phase != PH_IDLE) cur_phase = PH_STARTING;
            end
            CMD_ABORT: begin
                sess_size = '0;
                sent_ofs  = '0;
                conf_cnt  = '0;
                cur_chunk = 16'(P_MAX_CHUNK);
                cur_phase = PH_IDLE;
            end
            default: ;
        endcase

        // Report fields derived from the new state
        rep = '0;
        if (sess_size != 0) begin
            wide = (64'(conf_cnt) * PCT_SCALE) / 64'(sess_size);
            rep.percent = wide[6:0];
        end
        if (cur_chunk != 0) begin
            wide = (64'(sess_size) + 64'(cur_chunk) - 64'd1) / 64'(cur_chunk);
            rep.total_chunks = wide[31:0];
        end
        if (sent_ofs >= sess_size || cur_chunk == 0) begin
            next_len = '0;
            has      = 1'b0;
            last     = (sess_size != 0);
        end else begin
            remain   = sess_size - sent_ofs;
            next_len = (remain < 32'(cur_chunk)) ? remain[15:0] : cur_chunk;
            has      = 1'b1;
            last     = (33'(sent_ofs) + 33'(next_len) >= 33'(sess_size));
        end
        rep.phase             = cur_phase;
        rep.bytes_sent        = sent_ofs;
        rep.bytes_confirmed   = conf_cnt;
        rep.chunk_size        = cur_chunk;
        rep.chunk_length      = next_len;
        rep.chunk_has_data    = has;
        rep.chunk_is_last     = last;
        rep.status_kind       = kind;
        rep.status_error_code = ecode;
        rep.raw_status        = raw;
    endtask

    // Report for a session of size zero, as typed into the directed table
    function automatic t_out_item empty_session_report(input t_phase ph, input logic [15:0] cs,
                                                       input t_skind kind,
                                                       input logic [7:0] ecode,
                                                       input logic [7:0] raw);
        t_out_item rep;
        rep = '0;
        rep.phase             = ph;
        rep.chunk_size        = cs;
        rep.status_kind       = kind;
        rep.status_error_code = ecode;
        rep.raw_status        = raw;
        return rep;
    endfunction

    function automatic t_in_item cmd_item(input logic [2:0] cmd, input logic [15:0] mtu,
                                          input logic [15:0] wlen);
        t_in_item it;
        it = '0;
        it.cmd = cmd;
        it.mtu_size = mtu;
        it.written_length = wlen;
        return it;
    endfunction

    function automatic t_in_item status_item(input logic [2:0] cnt, input logic [7:0] b0,
                                             input logic [7:0] b1, input logic [7:0] b2,
                                             input logic [7:0] b3, input logic [7:0] b4);
        t_in_item it;
        it = '0;
        it.cmd = CMD_STATUS;
        it.status_count = cnt;
        it.status_byte0 = b0;
        it.status_byte1 = b1;
        it.status_byte2 = b2;
        it.status_byte3 = b3;
        it.status_byte4 = b4;
        return it;
    endfunction

    task automatic add_item(input t_in_item it);
        t_step_row row;
        row = '0;
        row.item = it;
        plan.insert(plan.size(), row);
    endtask

    task automatic add_fixed(input t_in_item it, input t_out_item want);
        t_step_row row;
        row = '0;
        row.item  = it;
        row.fixed = 1'b1;
        row.want  = want;
        plan.insert(plan.size(), row);
    endtask

    task automatic add_cfg(input t_cfg_idx idx, input logic [31:0] val);
        t_step_row row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        plan.insert(plan.size(), row);
    endtask

    // Sender: random gap unless steady, then hold the transaction until accepted. Runs from a falling edge.
    task automatic send_item(input t_in_item it, input logic fixed, input t_out_item want);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  = it;
        row_fixed  = fixed;
        row_want   = want;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic settle_block();
        i_in_valid = 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
    endtask

    task automatic load_register(input t_cfg_idx idx, input logic [31:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Scoreboard: check results, track register writes, predict each accepted transaction
    always @(posedge i_clk) begin : scoreboard
        t_out_item forecast;
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_reports.size() == 0) begin
                    note_failure("result with no transaction pending");
                end else begin
                    want = pending_reports.pop_front();
                    check_field("phase", 32'(o_out_data.phase), 32'(want.phase));
                    check_field("bytes_sent", o_out_data.bytes_sent, want.bytes_sent);
                    check_field("bytes_confirmed", o_out_data.bytes_confirmed,
                                want.bytes_confirmed);
                    check_field("percent", 32'(o_out_data.percent), 32'(want.percent));
                    check_field("chunk_size", 32'(o_out_data.chunk_size), 32'(want.chunk_size));
                    check_field("total_chunks", o_out_data.total_chunks, want.total_chunks);
                    check_field("chunk_length", 32'(o_out_data.chunk_length),
                                32'(want.chunk_length));
                    check_field("chunk_has_data", 32'(o_out_data.chunk_has_data),
                                32'(want.chunk_has_data));
                    check_field("chunk_is_last", 32'(o_out_data.chunk_is_last),
                                32'(want.chunk_is_last));
                    check_field("status_kind", 32'(o_out_data.status_kind),
                                32'(want.status_kind));
                    check_field("status_error_code", 32'(o_out_data.status_error_code),
                                32'(want.status_error_code));
                    check_field("raw_status", 32'(o_out_data.raw_status), 32'(want.raw_status));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IMAGE_TOTAL:   cfg_image    = i_cfg_data;
                    CFG_CODE_READY:    cfg_ready    = i_cfg_data[7:0];
                    CFG_CODE_PROGRESS: cfg_progress = i_cfg_data[7:0];
                    CFG_CODE_ERROR:    cfg_error    = i_cfg_data[7:0];
                    CFG_CODE_FINISHED: cfg_finished = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                predict_session_report(i_in_data, forecast);
                pending_reports.insert(pending_reports.size(), row_fixed ? row_want : forecast);
            end
        end
    end

    // Result receiver: random stall before each result unless steady
    initial begin : result_sink
        int hold;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            hold = steady ? 0 : $urandom_range(0, 4);
            if (hold > 0) begin
                i_out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Watchdog: too long without any handshake ends the run
    initial begin : watchdog
        int stuck;
        stuck = 0;
        wait (i_rst_n === 1'b1);
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        t_in_item    it;
        logic [31:0] img;
        logic [31:0] lim;
        logic [31:0] word;
        logic [15:0] next_len;
        logic [7:0]  codes[4];
        int          r;
        int          m;
        int          ph;
        int          k;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_IMAGE_TOTAL;
        i_cfg_data  = '0;
        row_fixed   = 1'b0;
        row_want    = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: size-zero session after reset, results typed in
        add_fixed(cmd_item(CMD_SPARE6, 16'h0, 16'h0),
                  empty_session_report(PH_IDLE, 16'(P_MAX_CHUNK), SK_UNKNOWN, 8'h0, 8'h0));
        // empty status packet
        add_fixed(status_item(3'd0, RST_CODE_READY, 8'h0, 8'h0, 8'h0, 8'h0),
                  empty_session_report(PH_IDLE, 16'(P_MAX_CHUNK), SK_UNKNOWN, 8'h0, 8'h0));
        add_fixed(status_item(3'd1, RST_CODE_READY, 8'h0, 8'h0, 8'h0, 8'h0),
                  empty_session_report(PH_IDLE, 16'(P_MAX_CHUNK), SK_READY, 8'h0,
                                       RST_CODE_READY));
        add_fixed(cmd_item(CMD_MTU, 16'h0, 16'h0),
                  empty_session_report(PH_IDLE, 16'(P_MIN_CHUNK), SK_UNKNOWN, 8'h0, 8'h0));
        add_fixed(cmd_item(CMD_MTU, 16'hFFFF, 16'hFFFF),
                  empty_session_report(PH_IDLE, 16'(P_MAX_CHUNK), SK_UNKNOWN, 8'h0, 8'h0));
        // MTU below the framing overhead
        add_fixed(cmd_item(CMD_MTU, 16'd2, 16'h0),
                  empty_session_report(PH_IDLE, 16'(P_MIN_CHUNK), SK_UNKNOWN, 8'h0, 8'h0));
        add_fixed(cmd_item(CMD_MTU, 16'(P_MAX_CHUNK + MTU_OVERHEAD), 16'h0),
                  empty_session_report(PH_IDLE, 16'(P_MAX_CHUNK), SK_UNKNOWN, 8'h0, 8'h0));
        add_fixed(status_item(3'd2, RST_CODE_ERROR, 8'hAB, 8'h0, 8'h0, 8'h0),
                  empty_session_report(PH_FAILED, 16'(P_MAX_CHUNK), SK_ERROR, 8'hAB,
                                       RST_CODE_ERROR));
        // one-byte error packet carries no code
        add_fixed(status_item(3'd1, RST_CODE_ERROR, 8'hCD, 8'h0, 8'h0, 8'h0),
                  empty_session_report(PH_FAILED, 16'(P_MAX_CHUNK), SK_ERROR, 8'h0,
                                       RST_CODE_ERROR));
        add_fixed(cmd_item(CMD_REWIND, 16'h0, 16'h0),
                  empty_session_report(PH_STARTING, 16'(P_MAX_CHUNK), SK_UNKNOWN, 8'h0, 8'h0));
        // byte count above five
        add_fixed(status_item(3'd7, RST_CODE_FINISHED, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                  empty_session_report(PH_COMPLETED, 16'(P_MAX_CHUNK), SK_FINISHED, 8'h0,
                                       RST_CODE_FINISHED));
        add_fixed(status_item(3'd5, RST_CODE_PROGRESS, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                  empty_session_report(PH_COMPLETED, 16'(P_MAX_CHUNK), SK_PROGRESS, 8'h0,
                                       RST_CODE_PROGRESS));
        add_fixed(cmd_item(CMD_ABORT, 16'hFFFF, 16'hFFFF),
                  empty_session_report(PH_IDLE, 16'(P_MAX_CHUNK), SK_UNKNOWN, 8'h0, 8'h0));
        add_fixed(status_item(3'd1, UNUSED_CODE, 8'h0, 8'h0, 8'h0, 8'h0),
                  empty_session_report(PH_IDLE, 16'(P_MAX_CHUNK), SK_UNKNOWN, 8'h0,
                                       UNUSED_CODE));

        // Directed: a small session walked to the end, checked by the model
        add_cfg(CFG_IMAGE_TOTAL, 32'd1000);
        add_item(cmd_item(CMD_OPEN, 16'd103, 16'h0));
        add_item(cmd_item(CMD_CONFIRM, 16'h0, 16'd64));
        add_item(status_item(3'd5, RST_CODE_PROGRESS, 8'hF4, 8'h01, 8'h00, 8'h00));
        // short progress packet zeroes the count
        add_item(status_item(3'd4, RST_CODE_PROGRESS, 8'hF4, 8'h01, 8'h00, 8'h00));
        add_item(cmd_item(CMD_MTU, 16'h0, 16'h0));
        add_item(cmd_item(CMD_CONFIRM, 16'h0, 16'hFFFF));
        add_item(status_item(3'd1, RST_CODE_FINISHED, 8'h0, 8'h0, 8'h0, 8'h0));
        add_item(cmd_item(CMD_REWIND, 16'h0, 16'h0));
        add_item(status_item(3'd5, RST_CODE_PROGRESS, 8'hFF, 8'hFF, 8'hFF, 8'hFF));

        // Directed: largest image, all codes equal so ready takes priority
        add_cfg(CFG_IMAGE_TOTAL, 32'hFFFF_FFFF);
        add_cfg(CFG_CODE_READY, 32'(SHARED_CODE));
        add_cfg(CFG_CODE_PROGRESS, 32'(SHARED_CODE));
        add_cfg(CFG_CODE_ERROR, 32'(SHARED_CODE));
        add_cfg(CFG_CODE_FINISHED, 32'(SHARED_CODE));
        add_item(cmd_item(CMD_OPEN, 16'hFFFF, 16'h0));
        add_item(status_item(3'd5, SHARED_CODE, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        add_item(cmd_item(CMD_CONFIRM, 16'h0, 16'hFFFF));

        foreach (plan[n]) begin
            if (plan[n].is_cfg) begin
                settle_block();
                load_register(plan[n].cfg_idx, plan[n].cfg_val);
            end else begin
                send_item(plan[n].item, plan[n].fixed, plan[n].want);
            end
        end

        // Random sessions, one register setting per phase
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            settle_block();
            case (ph)
                0:       img = 32'hFFFF_FFFF;
                1:       img = '0;
                2:       img = 32'd1;
                5:       img = $urandom();
                default: img = $urandom_range(1, 4000);
            endcase
            for (k = 0; k < 4; k++) codes[k] = 8'($urandom());
            if (ph == 1) begin
                codes[0] = 8'h00;
                codes[1] = 8'hFF;
                codes[2] = 8'h80;
                codes[3] = 8'h7F;
            end else if (ph == 3) begin
                codes[1] = codes[0];
                codes[2] = codes[0];
                codes[3] = codes[0];
            end
            load_register(CFG_IMAGE_TOTAL, img);
            load_register(CFG_CODE_READY, 32'(codes[0]));
            load_register(CFG_CODE_PROGRESS, 32'(codes[1]));
            load_register(CFG_CODE_ERROR, 32'(codes[2]));
            load_register(CFG_CODE_FINISHED, 32'(codes[3]));
            steady = (ph % 3 == 2);
            send_item(cmd_item(CMD_OPEN, 16'($urandom_range(0, 600)), 16'h0), 1'b0, '0);

            for (k = 1; k < ITEMS_PER_PHASE; k++) begin
                // hold off mid-phase until the block has drained
                if (k == ITEMS_PER_PHASE / 2) settle_block();

                // fully random fields; the command picked below overrides what it uses
                it.cmd            = 3'($urandom());
                it.mtu_size       = 16'($urandom());
                it.written_length = 16'($urandom());
                it.status_count   = 3'($urandom());
                it.status_byte0   = 8'($urandom());
                it.status_byte1   = 8'($urandom());
                it.status_byte2   = 8'($urandom());
                it.status_byte3   = 8'($urandom());
                it.status_byte4   = 8'($urandom());

                r = $urandom_range(0, 99);
                if (cur_phase inside {PH_IDLE, PH_COMPLETED, PH_FAILED} && r < 50) r = 0;
                if (r < 14) begin
                    it.cmd = (r < 6) ? CMD_OPEN : CMD_MTU;
                    m = $urandom_range(0, 99);
                    if (m < 70)
                        it.mtu_size = 16'($urandom_range(0, 600));
                    else if (m < 85)
                        it.mtu_size = ($urandom_range(0, 1) != 0) ? 16'hFFFF
                                                                   : 16'($urandom_range(0, 3));
                end else if (r < 54) begin
                    it.cmd = CMD_CONFIRM;
                    if (sent_ofs < sess_size) begin
                        lim = sess_size - sent_ofs;
                        next_len = (lim < 32'(cur_chunk)) ? lim[15:0] : cur_chunk;
                    end else begin
                        next_len = cur_chunk;
                    end
                    m = $urandom_range(0, 99);
                    if (m < 70)
                        it.written_length = next_len;
                    else if (m < 90)
                        it.written_length = 16'($urandom_range(0, int'(cur_chunk)));
                end else if (r < 84) begin
                    it.cmd = CMD_STATUS;
                    m = $urandom_range(0, 99);
                    if (m < 25)      it.status_byte0 = cfg_ready;
                    else if (m < 60) it.status_byte0 = cfg_progress;
                    else if (m < 70) it.status_byte0 = cfg_error;
                    else if (m < 82) it.status_byte0 = cfg_finished;
                    if ($urandom_range(0, 9) < 8)
                        it.status_count = (it.status_byte0 == cfg_progress) ? 3'd5
                                                        : 3'($urandom_range(1, 5));
                    if (it.status_byte0 == cfg_progress && $urandom_range(0, 4) != 0) begin
                        lim = (sess_size > 32'hCCCC_CCCC) ? 32'hFFFF_FFFF
                                                          : sess_size + sess_size / 4;
                        word = $urandom_range(0, lim);
                        {it.status_byte4, it.status_byte3,
                         it.status_byte2, it.status_byte1} = word;
                    end
                end else if (r < 89) begin
                    it.cmd = CMD_REWIND;
                end else if (r < 93) begin
                    it.cmd = CMD_ABORT;
                end else if (r < 97) begin
                    it.cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE7 : CMD_SPARE6;
                end
                send_item(it, 1'b0, '0);
            end
        end

        settle_block();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_reports.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_reports.size()));
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
